FILE: hdl/ppst_pkg.sv
// ----------------------------------------------------------------------------
// ppst_pkg
// Shared types, constants and the arctangent table for the pure pursuit
// steering block.
// ----------------------------------------------------------------------------
package ppst_pkg;

    localparam int MaxPointsDefault = 1024;
    localparam int CordicSteps      = 23;
    localparam int AngleMax         = 23040;
    localparam int QueueDepth       = 2;
    localparam int QueueAw          = 1;

    // Configuration register indexes.
    localparam logic [7:0] CFG_WHEELBASE = 8'd0;
    localparam logic [7:0] CFG_LA_GAIN   = 8'd1;
    localparam logic [7:0] CFG_LA_MIN    = 8'd2;
    localparam logic [7:0] CFG_LA_MAX    = 8'd3;

    // Input item kinds.
    localparam logic KIND_SPEED = 1'b0;

    // One finished path handed from the front part to the back part.
    typedef struct packed {
        logic               found;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [9:0]         idx;
        logic [15:0]        la;
    } ppst_job_t;

    // Status the queue reports to both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } ppst_qstat_t;

    typedef enum logic [2:0] {
        F_IDLE, F_LA, F_SQ, F_DIST, F_UPD, F_PUSH
    } ppst_fstate_t;

    typedef enum logic [3:0] {
        B_IDLE, B_PREP, B_SQRT, B_DMUL, B_CHK, B_NORM, B_CORD, B_DONE, B_OUT
    } ppst_bstate_t;

    // Rounded atan(2^-i) in 1/65536 degree.
    function automatic logic signed [31:0] atan_lut(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:  v = 32'sd2949120;
            5'd1:  v = 32'sd1740967;
            5'd2:  v = 32'sd919879;
            5'd3:  v = 32'sd466945;
            5'd4:  v = 32'sd234379;
            5'd5:  v = 32'sd117304;
            5'd6:  v = 32'sd58666;
            5'd7:  v = 32'sd29335;
            5'd8:  v = 32'sd14668;
            5'd9:  v = 32'sd7334;
            5'd10: v = 32'sd3667;
            5'd11: v = 32'sd1833;
            5'd12: v = 32'sd917;
            5'd13: v = 32'sd458;
            5'd14: v = 32'sd229;
            5'd15: v = 32'sd115;
            5'd16: v = 32'sd57;
            5'd17: v = 32'sd29;
            5'd18: v = 32'sd14;
            5'd19: v = 32'sd7;
            5'd20: v = 32'sd4;
            5'd21: v = 32'sd2;
            5'd22: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/ppst_front.sv
// ----------------------------------------------------------------------------
// ppst_front
// Accepts input words, freezes the lookahead at path start and keeps the
// running target search; pushes one job per finished path.
// ----------------------------------------------------------------------------
module ppst_front #(
    parameter int MAX_POINTS = ppst_pkg::MaxPointsDefault
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  logic [15:0]           s_speed_value,
    input  logic signed [15:0]    s_point_x,
    input  logic signed [15:0]    s_point_y,
    input  logic                  s_last_point,
    input  logic [15:0]           la_gain,
    input  logic [15:0]           la_min,
    input  logic [15:0]           la_max,
    input  ppst_pkg::ppst_qstat_t qstat,
    output logic                  push,
    output ppst_pkg::ppst_job_t   push_job
);
    import ppst_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);

    ppst_fstate_t       state_reg, state_next;
    logic [15:0]        speed_reg, la_reg;
    logic [31:0]        la_sq_reg, dsq_reg;
    logic               in_path_reg, ff_reg, far_v_reg, last_reg;
    logic [CW-1:0]      cnt_reg;
    logic signed [15:0] px_reg, py_reg, fx_reg, fy_reg, rx_reg, ry_reg;
    logic [9:0]         fidx_reg, ridx_reg;
    logic [30:0]        far_dsq_reg;
    logic [31:0]        gprod;
    logic [23:0]        ld_raw;
    logic [15:0]        ld_clamp;
    logic signed [31:0] px32, py32;
    logic [31:0]        dsq_now;

    // Lookahead from speed, with min then max clamp.
    always_comb begin
        gprod  = 32'(la_gain) * 32'(speed_reg);
        ld_raw = gprod[31:8];
        if (ld_raw < 24'(la_min)) begin
            ld_raw = 24'(la_min);
        end
        if (ld_raw > 24'(la_max)) begin
            ld_raw = 24'(la_max);
        end
        ld_clamp = ld_raw[15:0];
    end

    // Squared distance of the held point.
    always_comb begin
        px32    = 32'(px_reg);
        py32    = 32'(py_reg);
        dsq_now = unsigned'(px32 * px32) + unsigned'(py32 * py32);
    end

    // Next state and handshake.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        push       = 1'b0;
        case (state_reg)
            F_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_kind != KIND_SPEED) begin
                    state_next = in_path_reg ? F_DIST : F_LA;
                end
            end
            F_LA:   state_next = F_SQ;
            F_SQ:   state_next = F_DIST;
            F_DIST: state_next = F_UPD;
            F_UPD:  state_next = last_reg ? F_PUSH : F_IDLE;
            F_PUSH: begin
                if (!qstat.full) begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // The job chooses the first qualifying point, else the farthest one.
    always_comb begin
        push_job.found = ff_reg || far_v_reg;
        push_job.x     = ff_reg ? fx_reg : rx_reg;
        push_job.y     = ff_reg ? fy_reg : ry_reg;
        push_job.idx   = ff_reg ? fidx_reg : ridx_reg;
        push_job.la    = la_reg;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= F_IDLE;
            speed_reg   <= '0;
            la_reg      <= '0;
            in_path_reg <= 1'b0;
            cnt_reg     <= '0;
            ff_reg      <= 1'b0;
            far_v_reg   <= 1'b0;
            far_dsq_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == F_IDLE && s_valid && s_kind == KIND_SPEED) begin
                speed_reg <= s_speed_value;
            end
            if (state_reg == F_LA) begin
                la_reg      <= ld_clamp;
                in_path_reg <= 1'b1;
                cnt_reg     <= '0;
                ff_reg      <= 1'b0;
                far_v_reg   <= 1'b0;
                far_dsq_reg <= '0;
            end
            if (state_reg == F_UPD && cnt_reg < CW'(MAX_POINTS)) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (px_reg > 16'sd0) begin
                    if (!ff_reg && dsq_reg >= la_sq_reg) begin
                        ff_reg <= 1'b1;
                    end
                    if (!far_v_reg || dsq_reg[30:0] > far_dsq_reg) begin
                        far_v_reg   <= 1'b1;
                        far_dsq_reg <= dsq_reg[30:0];
                    end
                end
            end
            if (push) begin
                in_path_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && s_valid) begin
            px_reg   <= s_point_x;
            py_reg   <= s_point_y;
            last_reg <= s_last_point;
        end
        if (state_reg == F_SQ) begin
            la_sq_reg <= 32'(la_reg) * 32'(la_reg);
        end
        if (state_reg == F_DIST) begin
            dsq_reg <= dsq_now;
        end
        if (state_reg == F_UPD && cnt_reg < CW'(MAX_POINTS) && px_reg > 16'sd0) begin
            if (!ff_reg && dsq_reg >= la_sq_reg) begin
                fx_reg   <= px_reg;
                fy_reg   <= py_reg;
                fidx_reg <= 10'(cnt_reg);
            end
            if (!far_v_reg || dsq_reg[30:0] > far_dsq_reg) begin
                rx_reg   <= px_reg;
                ry_reg   <= py_reg;
                ridx_reg <= 10'(cnt_reg);
            end
        end
    end

endmodule

FILE: hdl/ppst_queue.sv
// ----------------------------------------------------------------------------
// ppst_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module ppst_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ppst_pkg::ppst_job_t   push_job,
    input  logic                  pop,
    output ppst_pkg::ppst_job_t   head,
    output ppst_pkg::ppst_qstat_t qstat
);
    import ppst_pkg::*;

    ppst_job_t        mem [QueueDepth];
    logic [QueueAw-1:0] wp_reg, rp_reg;
    logic [QueueAw:0]   cnt_reg;

    assign head        = mem[rp_reg];
    assign qstat.full  = (cnt_reg == (QueueAw + 1)'(QueueDepth));
    assign qstat.empty = (cnt_reg == '0);

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= push_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/ppst_back.sv
// ----------------------------------------------------------------------------
// ppst_back
// Computes the steering angle of one job: target range by a digit-serial
// square root, then the angle by a shared vectoring CORDIC stage.
// ----------------------------------------------------------------------------
module ppst_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [15:0]           wheelbase,
    input  ppst_pkg::ppst_job_t   head,
    input  ppst_pkg::ppst_qstat_t qstat,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_steer_angle,
    output logic [9:0]            m_target_index,
    output logic                  m_valid_res
);
    import ppst_pkg::*;

    ppst_bstate_t       state_reg, state_next;
    ppst_job_t          job_reg;
    logic [32:0]        nmag_reg;
    logic [47:0]        rad_reg;
    logic [26:0]        rem_reg;
    logic [23:0]        root_reg;
    logic [39:0]        d_reg;
    logic [4:0]         step_reg;
    logic signed [45:0] cx_reg, cy_reg;
    logic signed [31:0] z_reg;
    logic signed [15:0] ang_reg;
    logic [9:0]         idx_reg;
    logic               vres_reg;
    logic               neg;
    logic signed [31:0] jx32, jy32, zr;
    logic signed [16:0] y17;
    logic [16:0]        ay;
    logic [26:0]        remt, trial;
    logic signed [45:0] xs, ys;

    assign neg            = job_reg.y < 16'sd0;
    assign m_valid        = (state_reg == B_OUT);
    assign m_steer_angle  = ang_reg;
    assign m_target_index = idx_reg;
    assign m_valid_res    = vres_reg;

    // Operand preparation.
    always_comb begin
        jx32 = 32'(job_reg.x);
        jy32 = 32'(job_reg.y);
        y17  = 17'(job_reg.y);
        ay   = unsigned'(neg ? -y17 : y17);
    end

    // One square root digit.
    always_comb begin
        remt  = {rem_reg[24:0], rad_reg[47:46]};
        trial = {1'b0, root_reg, 2'b01};
    end

    // One CORDIC rotation and the final rounding.
    always_comb begin
        xs = cx_reg >>> step_reg;
        ys = cy_reg >>> step_reg;
        zr = (z_reg + 32'sd128) >>> 8;
        if (zr < 32'sd0) begin
            zr = 32'sd0;
        end
        if (zr > 32'(AngleMax)) begin
            zr = 32'(AngleMax);
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!qstat.empty) begin
                    pop        = 1'b1;
                    state_next = head.found ? B_PREP : B_OUT;
                end
            end
            B_PREP: state_next = B_SQRT;
            B_SQRT: state_next = (step_reg == 5'd0) ? B_DMUL : B_SQRT;
            B_DMUL: state_next = B_CHK;
            B_CHK:  state_next = (nmag_reg == '0 || d_reg == '0) ? B_OUT : B_NORM;
            B_NORM: state_next = ((cx_reg[45:40] | cy_reg[45:40]) == '0) ? B_NORM : B_CORD;
            B_CORD: state_next = (step_reg == 5'(CordicSteps - 1)) ? B_DONE : B_CORD;
            B_DONE: state_next = B_OUT;
            B_OUT:  state_next = m_ready ? B_IDLE : B_OUT;
            default: state_next = B_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                job_reg  <= head;
                ang_reg  <= '0;
                idx_reg  <= head.found ? head.idx : '0;
                vres_reg <= head.found;
            end
            B_PREP: begin
                rad_reg  <= {unsigned'(jx32 * jx32) + unsigned'(jy32 * jy32), 16'h0000};
                nmag_reg <= 33'(wheelbase) * 33'(ay);
                rem_reg  <= '0;
                root_reg <= '0;
                step_reg <= 5'd23;
            end
            B_SQRT: begin
                if (remt >= trial) begin
                    rem_reg  <= remt - trial;
                    root_reg <= {root_reg[22:0], 1'b1};
                end else begin
                    rem_reg  <= remt;
                    root_reg <= {root_reg[22:0], 1'b0};
                end
                rad_reg  <= {rad_reg[45:0], 2'b00};
                step_reg <= step_reg - 1'b1;
            end
            B_DMUL: begin
                d_reg <= 40'(root_reg) * 40'(job_reg.la);
            end
            B_CHK: begin
                cx_reg   <= 46'(d_reg);
                cy_reg   <= 46'({nmag_reg, 9'h000});
                z_reg    <= '0;
                step_reg <= '0;
                if (nmag_reg == '0) begin
                    ang_reg <= '0;
                end else if (neg) begin
                    ang_reg <= -16'(AngleMax);
                end else begin
                    ang_reg <= 16'(AngleMax);
                end
            end
            B_NORM: begin
                if ((cx_reg[45:40] | cy_reg[45:40]) == '0) begin
                    cx_reg <= cx_reg <<< 1;
                    cy_reg <= cy_reg <<< 1;
                end
            end
            B_CORD: begin
                if (cy_reg > 46'sd0) begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    z_reg  <= z_reg + atan_lut(step_reg);
                end else begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    z_reg  <= z_reg - atan_lut(step_reg);
                end
                step_reg <= step_reg + 1'b1;
            end
            B_DONE: begin
                ang_reg <= neg ? -16'(zr) : 16'(zr);
            end
            B_OUT: begin
                ang_reg <= ang_reg;
            end
            default: begin
                ang_reg <= ang_reg;
            end
        endcase
    end

endmodule

FILE: hdl/pure_pursuit_steering_top.sv
// ----------------------------------------------------------------------------
// pure_pursuit_steering_top
// Pure pursuit steering with a speed-dependent lookahead distance.
// ----------------------------------------------------------------------------
// A speed word is taken in the idle state. A path point goes through the
// front part's distance and update steps, and the first point of a path also
// through its lookahead and square steps. The last point then hands a job to
// a two-entry queue, waiting while the queue is full. The back part passes a
// path without target straight to its output; otherwise it runs 24 square
// root digits, then gives a fixed angle or goes on with up to 31 normalizing
// shifts and 23 CORDIC rotations, and then waits for any stall on the result;
// points of the next path are taken meanwhile. Configuration writes are taken
// every cycle.
module pure_pursuit_steering_top #(
    parameter int MAX_POINTS = ppst_pkg::MaxPointsDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [15:0]        s_speed_value,
    input  logic signed [15:0] s_point_x,
    input  logic signed [15:0] s_point_y,
    input  logic               s_last_point,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_steer_angle,
    output logic [9:0]         m_target_index,
    output logic               m_valid_res
);
    import ppst_pkg::*;

    logic [15:0] wb_reg, gain_reg, min_reg, max_reg;
    logic        push, pop;
    ppst_job_t   push_job, head;
    ppst_qstat_t qstat;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_reg   <= 16'd666;
            gain_reg <= 16'd128;
            min_reg  <= 16'd512;
            max_reg  <= 16'd2560;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WHEELBASE: wb_reg   <= cfg_data;
                CFG_LA_GAIN:   gain_reg <= cfg_data;
                CFG_LA_MIN:    min_reg  <= cfg_data;
                CFG_LA_MAX:    max_reg  <= cfg_data;
                default:       wb_reg   <= wb_reg;
            endcase
        end
    end

    ppst_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_kind, .s_speed_value,
        .s_point_x, .s_point_y, .s_last_point,
        .la_gain(gain_reg), .la_min(min_reg), .la_max(max_reg),
        .qstat, .push, .push_job
    );

    ppst_queue u_queue (
        .aclk, .aresetn, .push, .push_job, .pop, .head, .qstat
    );

    ppst_back u_back (
        .aclk, .aresetn, .wheelbase(wb_reg), .head, .qstat, .pop,
        .m_valid, .m_ready, .m_steer_angle, .m_target_index, .m_valid_res
    );

endmodule

FILE: hdl/ppst_checker.sv
// ----------------------------------------------------------------------------
// ppst_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ppst_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_steer_angle,
    input logic [9:0]         m_target_index,
    input logic               m_valid_res
);
    // A stalled result stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // A result without target carries zeros.
    a_notarget: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_steer_angle == 16'sd0 && m_target_index == 10'd0)
        else $error("missing target with nonzero fields");

    // The angle stays within the steering limit.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_steer_angle <= 16'sd23040 && m_steer_angle >= -16'sd23040)
        else $error("steering angle out of range");

    // Reset leaves no result offered.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

endmodule

bind pure_pursuit_steering_top ppst_checker u_ppst_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_steer_angle, .m_target_index,
    .m_valid_res
);

FILE: bench/ppst_checker.sv
// ----------------------------------------------------------------------------
// ppst_scoreboard
// Watches the configuration, point and result channels of the pure pursuit
// steering block. Each accepted input word updates a private copy of the
// block state; the expected steering result of every finished path is queued
// and compared field by field with the words that leave the block.
// ----------------------------------------------------------------------------
module ppst_scoreboard (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_kind,
    input  logic [15:0]        s_speed_value,
    input  logic signed [15:0] s_point_x,
    input  logic signed [15:0] s_point_y,
    input  logic               s_last_point,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_steer_angle,
    input  logic [9:0]         m_target_index,
    input  logic               m_valid_res,
    output int                 errors,
    output int                 pending
);
    import ppst_pkg::*;

    localparam int PathLimit = 1024;

    typedef struct {
        logic signed [15:0] angle;
        logic [9:0]         index;
        logic               found;
    } steer_word_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [9:0]         idx;
    } path_point_t;

    // Rounded atan(2^-i) in 1/65536 degree.
    localparam longint ArcTab [23] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
    };

    steer_word_t steer_queue[$];

    logic [15:0] wb_reg, gain_reg, la_min_reg, la_max_reg;
    logic [15:0] speed_now, la_frozen;
    logic        path_open, near_found, far_found;
    logic [10:0] path_count;
    logic [31:0] far_sq;
    path_point_t near_pt, far_pt;

    // Integer square root of a 64-bit value.
    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Steering angle toward a target point, 1/256 degree.
    function automatic logic signed [15:0] steer_toward(input path_point_t p,
                                                        input logic [15:0] wb,
                                                        input logic [15:0] la);
        longint          num, den, cx, cy, cz, mx, xs, ys;
        longint unsigned dsq;
        dsq = longint'(p.x) * p.x + longint'(p.y) * p.y;
        num = 2 * longint'(wb) * longint'(p.y) * 256;
        if (num == 0) return 16'sd0;
        den = longint'(root64(dsq << 16)) * longint'(la);
        if (den == 0) return (num > 0) ? 16'sd23040 : -16'sd23040;
        cx = den;
        cy = (num > 0) ? num : -num;
        mx = (cx > cy) ? cx : cy;
        while (mx < (64'sd1 << 40)) begin
            cx = cx * 2;
            cy = cy * 2;
            mx = mx * 2;
        end
        cz = 0;
        for (int i = 0; i < 23; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy > 0) begin
                cx = cx + ys;
                cy = cy - xs;
                cz = cz + ArcTab[i];
            end else begin
                cx = cx - ys;
                cy = cy + xs;
                cz = cz - ArcTab[i];
            end
        end
        cz = (cz + 128) >>> 8;
        if (cz < 0) cz = 0;
        if (cz > AngleMax) cz = AngleMax;
        return (num > 0) ? 16'(cz) : 16'(-cz);
    endfunction

    // Register file updates.
    task automatic apply_write(input logic [7:0] idx, input logic [15:0] val);
        case (idx)
            CFG_WHEELBASE: wb_reg = val;
            CFG_LA_GAIN:   gain_reg = val;
            CFG_LA_MIN:    la_min_reg = val;
            CFG_LA_MAX:    la_max_reg = val;
            default: ;
        endcase
    endtask

    // Track one accepted input word; queue a result at the end of a path.
    task automatic track_word();
        longint      la;
        logic [31:0] dsq;
        path_point_t p;
        steer_word_t w;
        if (s_kind == KIND_SPEED) begin
            speed_now = s_speed_value;
            return;
        end
        if (!path_open) begin
            la = (longint'(gain_reg) * longint'(speed_now)) >> 8;
            if (la < la_min_reg) la = la_min_reg;
            if (la > la_max_reg) la = la_max_reg;
            la_frozen  = 16'(la);
            path_open  = 1'b1;
            path_count = '0;
            near_found = 1'b0;
            far_found  = 1'b0;
            far_sq     = '0;
        end
        if (path_count < PathLimit) begin
            p.x = s_point_x;
            p.y = s_point_y;
            p.idx = path_count[9:0];
            path_count = path_count + 1;
            if (s_point_x > 0) begin
                dsq = 32'(longint'(s_point_x) * s_point_x + longint'(s_point_y) * s_point_y);
                if (!near_found && longint'(dsq) >= longint'(la_frozen) * la_frozen) begin
                    near_found = 1'b1;
                    near_pt = p;
                end
                if (!far_found || dsq > far_sq) begin
                    far_found = 1'b1;
                    far_sq = dsq;
                    far_pt = p;
                end
            end
        end
        if (!s_last_point) return;
        path_open = 1'b0;
        if (near_found || far_found) begin
            p = near_found ? near_pt : far_pt;
            w.angle = steer_toward(p, wb_reg, la_frozen);
            w.index = p.idx;
            w.found = 1'b1;
        end else begin
            w.angle = '0;
            w.index = '0;
            w.found = 1'b0;
        end
        steer_queue.insert(steer_queue.size(), w);
    endtask

    // Compare one result word with the oldest expectation.
    task automatic check_word();
        steer_word_t w;
        if (steer_queue.size() == 0) begin
            $error("unexpected result word: angle %0d index %0d valid %0d",
                   m_steer_angle, m_target_index, m_valid_res);
            errors++;
            return;
        end
        w = steer_queue.pop_front();
        if (m_steer_angle !== w.angle) begin
            $error("steer_angle: expected %0d, got %0d", w.angle, m_steer_angle);
            errors++;
        end
        if (m_target_index !== w.index) begin
            $error("target_index: expected %0d, got %0d", w.index, m_target_index);
            errors++;
        end
        if (m_valid_res !== w.found) begin
            $error("valid_res: expected %0d, got %0d", w.found, m_valid_res);
            errors++;
        end
    endtask

    initial begin
        errors  = 0;
        pending = 0;
    end

    // Sample all channels at the clock edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            wb_reg     = 16'd666;
            gain_reg   = 16'd128;
            la_min_reg = 16'd512;
            la_max_reg = 16'd2560;
            speed_now  = '0;
            la_frozen  = '0;
            path_open  = 1'b0;
            near_found = 1'b0;
            far_found  = 1'b0;
            path_count = '0;
            far_sq     = '0;
            steer_queue.delete();
        end else begin
            if (m_valid && m_ready) check_word();
            if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
            if (s_valid && s_ready) track_word();
        end
        pending = steer_queue.size();
    end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the pure pursuit steering block: a directed set of paths,
// then random paths and speed words under several register settings and
// three idling patterns. Results are checked by ppst_scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
    import ppst_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_kind = 1'b0;
    logic [15:0]        s_speed_value = '0;
    logic signed [15:0] s_point_x = '0;
    logic signed [15:0] s_point_y = '0;
    logic               s_last_point = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_steer_angle;
    logic [9:0]         m_target_index;
    logic               m_valid_res;
    int                 errors;
    int                 pending;
    int                 gap_pct = 0;
    int                 stall_pct = 0;

    always #5 aclk = ~aclk;

    pure_pursuit_steering_top dut (.*);

    ppst_scoreboard checker_i (.*);

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hold-off for the whole run.
    initial begin
        #30000000;
        $display("FAILURE");
        $finish;
    end

    // Send one input word; returns right after the edge that accepts it.
    task automatic send_word(input logic kind, input logic [15:0] spd,
                             input logic signed [15:0] px, input logic signed [15:0] py,
                             input logic last);
        if ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_speed_value <= spd;
        s_point_x     <= px;
        s_point_y     <= py;
        s_last_point  <= last;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Write one register; the caller lowers cfg_valid after the batch.
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Wait for all results, then let the back part go quiet.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    // A coordinate from one of three magnitude classes.
    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(2))
            0: return 16'($signed($urandom_range(1200)) - 600);
            1: return 16'($signed($urandom_range(8000)) - 4000);
            default: return 16'($urandom);
        endcase
    endfunction

    // One random path with occasional speed words mixed in.
    task automatic random_path(input int len);
        logic signed [15:0] px;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0)
                send_word(KIND_SPEED, 16'($urandom), 16'($urandom), 16'($urandom),
                          1'($urandom));
            px = rand_coord();
            if ($urandom_range(3) != 0 && px < 0) px = -px;
            send_word(~KIND_SPEED, 16'($urandom), px, rand_coord(), i == len - 1);
        end
    endtask

    // Register settings: wheelbase, gain, minimum, maximum.
    logic [15:0] settings [9][4] = '{
        '{16'd65535, 16'd65535, 16'd0,     16'd65535},
        '{16'd0,     16'd128,   16'd512,   16'd2560},
        '{16'd666,   16'd0,     16'd0,     16'd0},
        '{16'd1000,  16'd256,   16'd3000,  16'd700},
        '{16'd300,   16'd512,   16'd100,   16'd4000},
        '{16'd65535, 16'd0,     16'd65535, 16'd65535},
        '{16'd1,     16'd1,     16'd1,     16'd1},
        '{16'd666,   16'd128,   16'd512,   16'd2560},
        '{16'd2000,  16'd1000,  16'd200,   16'd20000}
    };

    initial begin
        int words;
        int seg;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under reset settings.
        gap_pct = 30;
        stall_pct = 30;
        send_word(KIND_SPEED, 16'd0, 16'sd0, 16'sd0, 1'b1);
        send_word(~KIND_SPEED, 16'd0, 16'sd0, 16'sd0, 1'b1);
        send_word(KIND_SPEED, 16'hffff, 16'sd0, 16'sd0, 1'b0);
        send_word(~KIND_SPEED, 16'd0, -16'sd32768, 16'sd32767, 1'b0);
        send_word(~KIND_SPEED, 16'd0, 16'sd32767, -16'sd32768, 1'b0);
        send_word(~KIND_SPEED, 16'd0, 16'sd100, 16'sd0, 1'b1);
        send_word(~KIND_SPEED, 16'd0, 16'sd300, 16'sd0, 1'b0);
        send_word(~KIND_SPEED, 16'd0, 16'sd400, -16'sd5, 1'b1);
        send_word(KIND_SPEED, 16'd0, 16'sd0, 16'sd0, 1'b0);
        send_word(~KIND_SPEED, 16'd0, 16'sd5000, 16'sd0, 1'b1);
        send_word(~KIND_SPEED, 16'd0, -16'sd1, 16'sd9, 1'b0);
        send_word(~KIND_SPEED, 16'd0, 16'sd100, 16'sd50, 1'b0);
        send_word(KIND_SPEED, 16'd20000, 16'sd0, 16'sd0, 1'b1);
        send_word(~KIND_SPEED, 16'd0, 16'sd3000, -16'sd2000, 1'b1);
        send_word(~KIND_SPEED, 16'd0, 16'sd1, 16'sd1, 1'b1);
        drain();

        // Random part: three idling patterns, three settings each.
        for (seg = 0; seg < 9; seg++) begin
            case (seg / 3)
                0: begin gap_pct = 9;  stall_pct = 84; end
                1: begin gap_pct = 84; stall_pct = 9;  end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            write_reg(CFG_WHEELBASE, settings[seg][0]);
            write_reg(CFG_LA_GAIN, settings[seg][1]);
            write_reg(CFG_LA_MIN, settings[seg][2]);
            write_reg(CFG_LA_MAX, settings[seg][3]);
            write_reg(8'($urandom_range(255, 4)), 16'($urandom));
            cfg_valid <= 1'b0;
            @(posedge aclk);
            words = 0;
            // Speed words mixed into paths are not counted, so the target is
            // set a little under the wanted number of words per segment.
            while (words < 103) begin
                if ($urandom_range(3) == 0) begin
                    send_word(KIND_SPEED, ($urandom_range(1) == 0) ?
                              16'($urandom_range(10000)) : 16'($urandom),
                              16'($urandom), 16'($urandom), 1'($urandom));
                    words++;
                end
                seg = seg;
                begin
                    int len;
                    len = $urandom_range(8, 1);
                    random_path(len);
                    words += len;
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ppst_pkg.sv
hdl/ppst_front.sv
hdl/ppst_queue.sv
hdl/ppst_back.sv
hdl/pure_pursuit_steering_top.sv
hdl/ppst_checker.sv
bench/ppst_checker.sv
bench/tb_top.sv
